### hw/rtl/fpsh_pkg.sv
// ----------------------------------------------------------------------------
// fpsh_pkg
// Shared types and constants of the selected-pixel histogram block.
// ----------------------------------------------------------------------------
package fpsh_pkg;

    // Value that the first word of every frame must carry.
    localparam logic [31:0] HEADER_WORD = 32'h0123_4567;

    // Largest value of a saturating 32-bit counter.
    localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

    // Configuration register indexes, decoded from the word address.
    localparam logic [0:0] CFG_SELECT_ROW    = 1'b0;
    localparam logic [0:0] CFG_SELECT_COLUMN = 1'b1;

    // Kind of a result word.
    typedef enum logic [1:0] {
        KIND_SAMPLE    = 2'd0,
        KIND_HDR_ERROR = 2'd1,
        KIND_BIN_COUNT = 2'd2
    } kind_t;

    // Pixel selection held in the configuration registers.
    typedef struct packed {
        logic [6:0] select_row;
        logic [6:0] select_column;
    } fpsh_cfg_t;

    // Request handed from the frame controller to the histogram stage.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] sample_value;
        logic [31:0] sample_number;
        logic [31:0] overflow_count;
        logic        bin_rd;
        logic        bin_inc;
    } fpsh_req_t;

    // Finished result word.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] sample_value;
        logic [31:0] sample_number;
        logic [31:0] bin_count;
        logic [31:0] overflow_count;
    } fpsh_res_t;

endpackage

### hw/rtl/fpsh_if.sv
// ----------------------------------------------------------------------------
// fpsh_if
// Valid/ready channels for frame words in and result words out.
// ----------------------------------------------------------------------------
interface fpsh_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] frame_word;
    logic        first_flag;
    logic        last_flag;
    logic [13:0] bin_index;

    modport source (
        output valid, action, frame_word, first_flag, last_flag, bin_index,
        input  ready
    );
    modport sink (
        input  valid, action, frame_word, first_flag, last_flag, bin_index,
        output ready
    );
endinterface

interface fpsh_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] sample_value;
    logic [31:0] sample_number;
    logic [31:0] bin_count;
    logic [31:0] overflow_count;

    modport source (
        output valid, kind, sample_value, sample_number, bin_count, overflow_count,
        input  ready
    );
    modport sink (
        input  valid, kind, sample_value, sample_number, bin_count, overflow_count,
        output ready
    );
endinterface

### hw/rtl/fpsh_cfg_regs.sv
// ----------------------------------------------------------------------------
// fpsh_cfg_regs
// APB register file holding the selected row and column.
// ----------------------------------------------------------------------------
module fpsh_cfg_regs
    import fpsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output fpsh_cfg_t   cfg
);

    logic [6:0] select_row_reg;
    logic [6:0] select_column_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes at the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_row_reg    <= '0;
            select_column_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                CFG_SELECT_ROW:    select_row_reg    <= pwdata[6:0];
                CFG_SELECT_COLUMN: select_column_reg <= pwdata[6:0];
                default:           ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        case (paddr[2])
            CFG_SELECT_ROW:    prdata = {25'd0, select_row_reg};
            CFG_SELECT_COLUMN: prdata = {25'd0, select_column_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.select_row    = select_row_reg;
    assign cfg.select_column = select_column_reg;

endmodule

### hw/rtl/fpsh_frame_ctrl.sv
// ----------------------------------------------------------------------------
// fpsh_frame_ctrl
// Header check, pixel position counters, sample and overflow counters.
// ----------------------------------------------------------------------------
module fpsh_frame_ctrl
    import fpsh_pkg::*;
#(
    parameter int COLUMNS  = 96,
    parameter int ROWS     = 98,
    parameter int ADC_BINS = 16384,
    parameter int AW       = 14
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic          action,
    input  logic [31:0]   frame_word,
    input  logic          first_flag,
    input  logic          last_flag,
    input  logic [13:0]   bin_index,
    input  fpsh_cfg_t     cfg,
    output logic          req_valid,
    output fpsh_req_t     req,
    output logic [AW-1:0] req_addr
);

    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic          frame_ok_reg, frame_ok_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [31:0]   ovf_reg, ovf_next;
    logic [31:0]   smp_reg, smp_next;

    logic [31:0]   bin_ext;
    logic          word_in_range;
    logic          bin_in_range;
    logic          at_select;

    assign bin_ext       = 32'(bin_index);
    assign word_in_range = frame_word < 32'(ADC_BINS);
    assign bin_in_range  = bin_ext < 32'(ADC_BINS);
    assign at_select     = (32'(col_reg) == 32'(cfg.select_column)) &&
                           (32'(row_reg) == 32'(cfg.select_row));

    // Per-word decision and next state of the frame bookkeeping.
    always_comb
    begin
        frame_ok_next = frame_ok_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        ovf_next      = ovf_reg;
        smp_next      = smp_reg;
        req_valid     = 1'b0;
        req           = '0;
        req.kind      = KIND_SAMPLE;
        req_addr      = '0;

        if (fire)
        begin
            if (action)
            begin
                // Bin read: no state changes.
                req_valid          = 1'b1;
                req.kind           = KIND_BIN_COUNT;
                req.bin_rd         = bin_in_range;
                req.overflow_count = ovf_reg;
                req_addr           = bin_ext[AW-1:0];
            end
            else if (last_flag)
            begin
                frame_ok_next = 1'b0;
            end
            else if (first_flag)
            begin
                col_next = '0;
                row_next = '0;
                if (frame_word == HEADER_WORD)
                begin
                    frame_ok_next = 1'b1;
                end
                else
                begin
                    frame_ok_next      = 1'b0;
                    req_valid          = 1'b1;
                    req.kind           = KIND_HDR_ERROR;
                    req.overflow_count = ovf_reg;
                end
            end
            else if (frame_ok_reg)
            begin
                // Step the column, wrapping into the row.
                if (col_reg == CW'(COLUMNS - 1))
                begin
                    col_next = '0;
                    row_next = (row_reg == RW'(ROWS - 1)) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end

                if (at_select)
                begin
                    req_valid         = 1'b1;
                    req.kind          = KIND_SAMPLE;
                    req.sample_value  = frame_word;
                    req.sample_number = smp_reg;
                    smp_next          = smp_reg + 32'd1;
                    if (word_in_range)
                    begin
                        req.bin_rd  = 1'b1;
                        req.bin_inc = 1'b1;
                        req_addr    = frame_word[AW-1:0];
                    end
                    else if (ovf_reg != SAT_MAX)
                    begin
                        ovf_next = ovf_reg + 32'd1;
                    end
                    req.overflow_count = ovf_next;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ok_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            ovf_reg      <= '0;
            smp_reg      <= '0;
        end
        else
        begin
            frame_ok_reg <= frame_ok_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            ovf_reg      <= ovf_next;
            smp_reg      <= smp_next;
        end
    end

endmodule

### hw/rtl/fpsh_hist_mem.sv
// ----------------------------------------------------------------------------
// fpsh_hist_mem
// Histogram memory with clearing pass, read-modify-write stage and forwarding.
// ----------------------------------------------------------------------------
module fpsh_hist_mem
    import fpsh_pkg::*;
#(
    parameter int ADC_BINS = 16384,
    parameter int AW       = 14
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  fpsh_req_t     req,
    input  logic [AW-1:0] req_addr,
    input  logic          advance,
    output logic          clr_busy,
    output logic          s1_valid,
    output fpsh_res_t     res
);

    logic [31:0]   mem [ADC_BINS];
    logic [31:0]   rdata_reg;

    logic          clr_active_reg, clr_active_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic          s1_valid_reg, s1_valid_next;
    fpsh_req_t     s1_req_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_fire;

    logic          lw_valid_reg;
    logic [AW-1:0] lw_addr_reg;
    logic [31:0]   lw_data_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [31:0]   cur_count;
    logic [31:0]   inc_count;

    assign clr_busy = clr_active_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_fire  = s1_valid_reg && advance;

    // Clearing pass after reset, one bin per cycle.
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == AW'(ADC_BINS - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    // The most recent write stands in for a read that raced it.
    assign cur_count = (lw_valid_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg
                                                                     : rdata_reg;
    assign inc_count = (cur_count == SAT_MAX) ? cur_count : cur_count + 32'd1;

    // Write port: clearing pass or bin update.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = s1_addr_reg;
        wr_data = inc_count;
        if (clr_active_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else if (s1_fire && s1_req_reg.bin_inc)
        begin
            wr_en = 1'b1;
        end
    end

    // Histogram memory, registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req_valid && req.bin_rd)
        begin
            rdata_reg <= mem[req_addr];
        end
    end

    // Stage valid.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_valid)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            lw_valid_reg   <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= s1_valid_next;
            if (wr_en)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    // Stage payload and last-write record.
    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            s1_req_reg  <= req;
            s1_addr_reg <= req_addr;
        end
        if (wr_en)
        begin
            lw_addr_reg <= wr_addr;
            lw_data_reg <= wr_data;
        end
    end

    // Result of the item in the stage.
    always_comb
    begin
        res.kind           = s1_req_reg.kind;
        res.sample_value   = s1_req_reg.sample_value;
        res.sample_number  = s1_req_reg.sample_number;
        res.overflow_count = s1_req_reg.overflow_count;
        if (s1_req_reg.bin_inc)
        begin
            res.bin_count = inc_count;
        end
        else if (s1_req_reg.bin_rd)
        begin
            res.bin_count = cur_count;
        end
        else
        begin
            res.bin_count = '0;
        end
    end

endmodule

### hw/rtl/frame_pixel_select_histogram_top.sv
// Throughput: one word per cycle unless clearing or an output stall holds
// frame_ch.ready low. A word enters the stage register, where the histogram
// memory is read, then the output register, as its bin is written back with
// the last write forwarded. Reset: all control state clears, then a clearing
// pass zeroes the histogram while frame_ch.ready is low; APB writes are taken.
// ----------------------------------------------------------------------------
// frame_pixel_select_histogram_top
// Selected-pixel value histogram over detector frames.
// ----------------------------------------------------------------------------
module frame_pixel_select_histogram_top
    import fpsh_pkg::*;
#(
    parameter int COLUMNS  = 96,
    parameter int ROWS     = 98,
    parameter int ADC_BINS = 16384
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    fpsh_in_if.sink     frame_ch,
    fpsh_out_if.source  result_ch
);

    localparam int AW = $clog2(ADC_BINS);

    fpsh_cfg_t     cfg;
    fpsh_req_t     req;
    fpsh_res_t     res;
    logic          req_valid;
    logic [AW-1:0] req_addr;
    logic          clr_busy;
    logic          s1_valid;
    logic          advance;
    logic          in_fire;

    logic          out_valid_reg;
    fpsh_res_t     out_reg;

    // Handshake: the stage moves on when the output register is free or drains.
    assign advance        = !out_valid_reg || result_ch.ready;
    assign frame_ch.ready = !clr_busy && (!s1_valid || advance);
    assign in_fire        = frame_ch.valid && frame_ch.ready;

    fpsh_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpsh_frame_ctrl #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .ADC_BINS (ADC_BINS),
        .AW       (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_fire),
        .action     (frame_ch.action),
        .frame_word (frame_ch.frame_word),
        .first_flag (frame_ch.first_flag),
        .last_flag  (frame_ch.last_flag),
        .bin_index  (frame_ch.bin_index),
        .cfg        (cfg),
        .req_valid  (req_valid),
        .req        (req),
        .req_addr   (req_addr)
    );

    fpsh_hist_mem #(
        .ADC_BINS (ADC_BINS),
        .AW       (AW)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_addr  (req_addr),
        .advance   (advance),
        .clr_busy  (clr_busy),
        .s1_valid  (s1_valid),
        .res       (res)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_valid && advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid && advance)
        begin
            out_reg <= res;
        end
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.kind           = out_reg.kind;
    assign result_ch.sample_value   = out_reg.sample_value;
    assign result_ch.sample_number  = out_reg.sample_number;
    assign result_ch.bin_count      = out_reg.bin_count;
    assign result_ch.overflow_count = out_reg.overflow_count;

endmodule

### bench/frame_pixel_select_histogram_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_pixel_select_histogram_top_tb
// Self-checking bench for the selected-pixel histogram block. Frame words and
// bin reads go in over the input channel, and a bench-side predictor of the
// frame tracker and histogram works out every result word. Each result word
// is checked field by field against the oldest prediction. Directed frames
// cover headers, last words, overflow and reads. Frames that run past the end
// of the first row cover the last column and the wrap into the next row.
// Random frames then run under several pixel selections with random idling on
// both sides and one long output stall.
// ----------------------------------------------------------------------------
module frame_pixel_select_histogram_top_tb
    import fpsh_pkg::*;
();

    localparam int FRAME_COLUMNS    = 96;
    localparam int FRAME_ROWS       = 98;
    localparam int ADC_BINS         = 16384;
    localparam int RANDOM_WORDS     = 1250;
    localparam int RANDOM_PHASES    = 6;
    localparam int DRAIN_CYCLES     = 8;
    localparam int STALL_LIMIT      = 80000;
    localparam int HOLD_OFF_CYCLES  = 200;

    // Register byte addresses.
    localparam logic [2:0] ROW_ADDR = {CFG_SELECT_ROW, 2'b00};
    localparam logic [2:0] COL_ADDR = {CFG_SELECT_COLUMN, 2'b00};

    // Input word actions.
    localparam logic ACT_FRAME_WORD = 1'b0;
    localparam logic ACT_READ_BIN   = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] frame_word;
        logic        first_flag;
        logic        last_flag;
        logic [13:0] bin_index;
    } frame_item_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fpsh_in_if  frame_ch ();
    fpsh_out_if result_ch ();

    frame_pixel_select_histogram_top #(
        .COLUMNS  (FRAME_COLUMNS),
        .ROWS     (FRAME_ROWS),
        .ADC_BINS (ADC_BINS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .frame_ch  (frame_ch),
        .result_ch (result_ch)
    );

    // Predicted state of the frame tracker and histogram.
    logic [6:0]  sel_row;
    logic [6:0]  sel_col;
    logic        frame_open;
    int          col_pos;
    int          row_pos;
    logic [31:0] bin_tally [ADC_BINS];
    logic [31:0] overflow_tally;
    logic [31:0] sample_seq;
    fpsh_res_t   result_words_due [$];

    int mismatches      = 0;
    int words_sent      = 0;
    int samples_seen    = 0;
    int hdr_errors_seen = 0;
    int bin_reads_seen  = 0;
    int idle_cycles     = 0;
    int sink_hold_request = 0;
    bit source_idle_en  = 1'b1;
    bit sink_idle_en    = 1'b1;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch in %s at %0t: expected %h, got %h", field, $time, want, got);
    endfunction

    // Advance the predicted pixel position, wrapping columns into rows.
    function automatic void step_pixel_position();
        if (col_pos + 1 >= FRAME_COLUMNS)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= FRAME_ROWS) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos++;
        end
    endfunction

    // Apply one accepted word to the predicted state and queue its result word.
    function automatic void histogram_step(frame_item_t w);
        fpsh_res_t r;
        r = '0;
        if (w.action == ACT_READ_BIN)
        begin
            r.kind           = KIND_BIN_COUNT;
            r.bin_count      = (w.bin_index < ADC_BINS) ? bin_tally[w.bin_index] : '0;
            r.overflow_count = overflow_tally;
            result_words_due.push_back(r);
        end
        else if (w.last_flag)
        begin
            frame_open = 1'b0;
        end
        else if (w.first_flag)
        begin
            col_pos = 0;
            row_pos = 0;
            if (w.frame_word == HEADER_WORD)
            begin
                frame_open = 1'b1;
            end
            else
            begin
                frame_open       = 1'b0;
                r.kind           = KIND_HDR_ERROR;
                r.overflow_count = overflow_tally;
                result_words_due.push_back(r);
            end
        end
        else if (frame_open)
        begin
            if (col_pos == sel_col && row_pos == sel_row)
            begin
                if (w.frame_word < 32'(ADC_BINS))
                begin
                    if (bin_tally[w.frame_word] != SAT_MAX)
                        bin_tally[w.frame_word]++;
                    r.bin_count = bin_tally[w.frame_word];
                end
                else if (overflow_tally != SAT_MAX)
                begin
                    overflow_tally++;
                end
                r.kind           = KIND_SAMPLE;
                r.sample_value   = w.frame_word;
                r.sample_number  = sample_seq;
                r.overflow_count = overflow_tally;
                sample_seq++;
                result_words_due.push_back(r);
            end
            step_pixel_position();
        end
    endfunction

    // Predict on each accepted input word, then check each accepted result word.
    always @(posedge clk)
    begin : word_monitor
        frame_item_t taken;
        fpsh_res_t   want;
        if (rst_n)
        begin
            if (frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1)
            begin
                taken.action     = frame_ch.action;
                taken.frame_word = frame_ch.frame_word;
                taken.first_flag = frame_ch.first_flag;
                taken.last_flag  = frame_ch.last_flag;
                taken.bin_index  = frame_ch.bin_index;
                histogram_step(taken);
            end
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                if (result_words_due.size() == 0)
                begin
                    note_mismatch("result word with nothing due (kind)", '0,
                                  32'(result_ch.kind));
                end
                else
                begin
                    want = result_words_due.pop_front();
                    case (want.kind)
                        KIND_SAMPLE:    samples_seen++;
                        KIND_HDR_ERROR: hdr_errors_seen++;
                        default:        bin_reads_seen++;
                    endcase
                    if (result_ch.kind !== want.kind)
                        note_mismatch("kind", 32'(want.kind), 32'(result_ch.kind));
                    if (result_ch.sample_value !== want.sample_value)
                        note_mismatch("sample_value", want.sample_value,
                                      result_ch.sample_value);
                    if (result_ch.sample_number !== want.sample_number)
                        note_mismatch("sample_number", want.sample_number,
                                      result_ch.sample_number);
                    if (result_ch.bin_count !== want.bin_count)
                        note_mismatch("bin_count", want.bin_count, result_ch.bin_count);
                    if (result_ch.overflow_count !== want.overflow_count)
                        note_mismatch("overflow_count", want.overflow_count,
                                      result_ch.overflow_count);
                end
            end
        end
    end

    // Result sink: random hold-offs per word, plus one long hold-off on request.
    initial
    begin : result_sink
        int gap;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold_request > 0)
            begin
                gap = sink_hold_request;
                sink_hold_request = 0;
            end
            else
            begin
                gap = sink_idle_en ? $urandom_range(0, 3) : 0;
            end
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("frame_pixel_select_histogram_top test failed");
        $finish;
    end

    function automatic frame_item_t make_item(logic action, logic [31:0] word, logic first,
                                              logic last, logic [13:0] bin);
        frame_item_t it;
        it.action     = action;
        it.frame_word = word;
        it.first_flag = first;
        it.last_flag  = last;
        it.bin_index  = bin;
        return it;
    endfunction

    // Offer one word and return at the edge where it is taken.
    task automatic send_word(input frame_item_t it);
        int gap;
        gap = source_idle_en ? $urandom_range(0, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_ch.valid      <= 1'b1;
        frame_ch.action     <= it.action;
        frame_ch.frame_word <= it.frame_word;
        frame_ch.first_flag <= it.first_flag;
        frame_ch.last_flag  <= it.last_flag;
        frame_ch.bin_index  <= it.bin_index;
        do @(posedge clk); while (frame_ch.ready !== 1'b1);
        words_sent++;
    endtask

    task automatic send_frame_word(input logic [31:0] word, input logic first,
                                   input logic last);
        send_word(make_item(ACT_FRAME_WORD, word, first, last, 14'($urandom)));
    endtask

    task automatic read_bin(input logic [13:0] bin);
        send_word(make_item(ACT_READ_BIN, $urandom, 1'($urandom), 1'($urandom), bin));
    endtask

    // Let the block drain, then allow for words still in its pipeline.
    task automatic wait_idle();
        @(negedge clk);
        frame_ch.valid <= 1'b0;
        while (result_words_due.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (addr == COL_ADDR)
            sel_col = data[6:0];
        else
            sel_row = data[6:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Program the selected pixel while idle and read both registers back.
    task automatic set_pixel_select(input logic [6:0] row, input logic [6:0] col);
        logic [31:0] readback;
        wait_idle();
        apb_write(ROW_ADDR, {25'b0, row});
        apb_write(COL_ADDR, {25'b0, col});
        apb_read(ROW_ADDR, readback);
        if (readback !== {25'b0, sel_row})
            note_mismatch("select_row readback", {25'b0, sel_row}, readback);
        apb_read(COL_ADDR, readback);
        if (readback !== {25'b0, sel_col})
            note_mismatch("select_column readback", {25'b0, sel_col}, readback);
    endtask

    function automatic logic [31:0] hot_bin(int idx);
        case (idx)
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd2;
            3:       return 32'd3;
            4:       return 32'd100;
            5:       return 32'd8191;
            6:       return 32'd16382;
            default: return 32'd16383;
        endcase
    endfunction

    // Pixel values lean on a few hot bins so that counts build up.
    function automatic logic [31:0] pick_pixel_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return hot_bin($urandom_range(0, 7));
            4, 5, 6:    return 32'($urandom_range(0, ADC_BINS - 1));
            7:          return 32'(ADC_BINS + $urandom_range(0, 3));
            8:          return $urandom();
            default:    return ($urandom_range(0, 1) != 0) ? SAT_MAX : HEADER_WORD;
        endcase
    endfunction

    function automatic logic [13:0] pick_bin();
        if ($urandom_range(0, 1) != 0)
            return 14'(hot_bin($urandom_range(0, 7)));
        return 14'($urandom_range(0, ADC_BINS - 1));
    endfunction

    // Good header, a run of pixel words, and a last word.
    task automatic send_frame(input int pixel_words);
        send_frame_word(HEADER_WORD, 1'b0 | 1'b1, 1'b0);
        for (int i = 0; i < pixel_words; i++)
            send_frame_word(pick_pixel_value(), 1'b0, 1'b0);
        send_frame_word($urandom, 1'b0, 1'b1);
    endtask

    // Mostly well-formed frames that reach the selected pixel, with noise mixed in.
    task automatic send_random_frame(input int select_pos);
        int pixel_words;
        pixel_words = ($urandom_range(0, 3) == 0) ? $urandom_range(0, select_pos)
                                                   : select_pos + 1 + $urandom_range(0, 4);
        // Occasional noise ahead of the frame.
        case ($urandom_range(0, 11))
            0: send_frame_word($urandom, 1'b0, 1'b0);
            1: send_frame_word(($urandom_range(0, 1) != 0) ? HEADER_WORD : $urandom,
                               1'b1, 1'b1);
            2: send_word(make_item(1'($urandom), $urandom, 1'($urandom), 1'($urandom),
                                   14'($urandom)));
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0)
            send_frame_word(($urandom_range(0, 1) != 0) ?
                            HEADER_WORD ^ (32'h1 << $urandom_range(0, 31)) : $urandom,
                            1'b1, 1'b0);
        else
            send_frame_word(HEADER_WORD, 1'b1, 1'b0);
        for (int i = 0; i < pixel_words; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                read_bin(pick_bin());
            send_frame_word(pick_pixel_value(), 1'b0, 1'b0);
        end
        // Most frames close with a last word; some run straight into the next header.
        if ($urandom_range(0, 6) != 0)
            send_frame_word($urandom, 1'($urandom_range(0, 3) == 0), 1'b1);
    endtask

    // Short directed frames with the reset selection of row 0, column 0.
    task automatic test_directed_cases();
        read_bin(14'd0);
        send_frame_word(HEADER_WORD, 1'b1, 1'b0);
        send_frame_word(32'd0, 1'b0, 1'b0);
        send_frame_word(32'd1, 1'b0, 1'b0);
        send_frame_word(32'd0, 1'b0, 1'b1);
        // A word after the last word lies outside any frame.
        send_frame_word(32'd7, 1'b0, 1'b0);
        send_frame_word(HEADER_WORD, 1'b1, 1'b0);
        send_frame_word(32'd16383, 1'b0, 1'b0);
        // A new header without a last word restarts the frame.
        send_frame_word(HEADER_WORD, 1'b1, 1'b0);
        send_frame_word(32'd16384, 1'b0, 1'b0);
        send_frame_word(HEADER_WORD, 1'b1, 1'b0);
        send_frame_word(SAT_MAX, 1'b0, 1'b0);
        send_frame_word(32'd0, 1'b0, 1'b1);
        // Bad header, then the rest of that frame is ignored.
        send_frame_word(32'h0123_4566, 1'b1, 1'b0);
        send_frame_word(32'd0, 1'b0, 1'b0);
        send_frame_word(32'd0, 1'b0, 1'b1);
        // A word marked both first and last is skipped, good header or not.
        send_frame_word(HEADER_WORD, 1'b1, 1'b1);
        send_frame_word(32'd0, 1'b0, 1'b0);
        send_frame_word(32'hDEAD_BEEF, 1'b1, 1'b1);
        // The header value as pixel data lands in the overflow counter.
        send_frame_word(HEADER_WORD, 1'b1, 1'b0);
        send_frame_word(HEADER_WORD, 1'b0, 1'b0);
        // Reads ignore every frame field.
        send_word(make_item(ACT_READ_BIN, HEADER_WORD, 1'b1, 1'b1, 14'h3FFF));
        read_bin(14'd0);
        read_bin(14'd5);
        send_frame_word(32'd0, 1'b0, 1'b1);
    endtask

    // Frames for the last column, the wrap into the second row and unreachable selections.
    task automatic test_pixel_extremes();
        source_idle_en = 1'b0;
        set_pixel_select(7'd0, 7'(FRAME_COLUMNS - 1));
        send_frame(FRAME_COLUMNS + 2);
        set_pixel_select(7'd1, 7'd0);
        send_frame(FRAME_COLUMNS + 4);
        set_pixel_select(7'h7F, 7'h7F);
        send_frame(40);
        set_pixel_select(7'd0, 7'(FRAME_COLUMNS));
        send_frame(FRAME_COLUMNS + 4);
        source_idle_en = 1'b1;
    endtask

    // Random frames over several selections and idling patterns.
    task automatic test_random_traffic();
        int select_pos;
        int phase_end;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            source_idle_en = (phase % 3 != 1);
            sink_idle_en   = (phase % 3 != 2);
            case (phase)
                2:       set_pixel_select(7'd1, 7'($urandom_range(0, 3)));
                4:       set_pixel_select(7'($urandom_range(FRAME_ROWS, 127)),
                                          7'($urandom_range(0, 127)));
                default: set_pixel_select(7'd0, 7'($urandom_range(0, 7)));
            endcase
            // Unreachable selections still get short frames.
            if (sel_row < FRAME_ROWS && sel_col < FRAME_COLUMNS)
                select_pos = sel_row * FRAME_COLUMNS + sel_col;
            else
                select_pos = 16;
            phase_end = words_sent + RANDOM_WORDS / RANDOM_PHASES;
            while (words_sent < phase_end)
                send_random_frame(select_pos);
        end
        source_idle_en = 1'b1;
        sink_idle_en   = 1'b1;
    endtask

    // The sink holds off for a long stretch while reads keep coming.
    task automatic test_output_stall();
        set_pixel_select(7'd0, 7'd3);
        source_idle_en    = 1'b0;
        sink_hold_request = HOLD_OFF_CYCLES;
        repeat (40) read_bin(pick_bin());
        send_frame(8);
        repeat (10) read_bin(pick_bin());
        source_idle_en = 1'b1;
    endtask

    initial
    begin : stimulus
        sel_row        = '0;
        sel_col        = '0;
        frame_open     = 1'b0;
        col_pos        = 0;
        row_pos        = 0;
        overflow_tally = '0;
        sample_seq     = '0;
        foreach (bin_tally[i])
            bin_tally[i] = '0;

        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        frame_ch.valid      = 1'b0;
        frame_ch.action     = ACT_FRAME_WORD;
        frame_ch.frame_word = '0;
        frame_ch.first_flag = 1'b0;
        frame_ch.last_flag  = 1'b0;
        frame_ch.bin_index  = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_pixel_extremes();
        test_random_traffic();
        test_output_stall();
        wait_idle();

        $display("Covered %0d input words: %0d pixel samples, %0d header errors,",
                 words_sent, samples_seen, hdr_errors_seen);
        $display("%0d bin reads, the last column, the row change, unreachable pixels %s",
                 bin_reads_seen, "and a long output stall.");
        if (mismatches == 0)
            $display("frame_pixel_select_histogram_top test passed");
        else
            $display("frame_pixel_select_histogram_top test failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/fpsh_pkg.sv
hw/rtl/fpsh_if.sv
hw/rtl/fpsh_cfg_regs.sv
hw/rtl/fpsh_frame_ctrl.sv
hw/rtl/fpsh_hist_mem.sv
hw/rtl/frame_pixel_select_histogram_top.sv
bench/frame_pixel_select_histogram_top_tb.sv
